// File: hdl/lbp_pkg.sv
// ----------------------------------------------------------------------------
// lbp_pkg: shared types and constants for the 3x3 local binary pattern filter
// Request and response payloads, column store geometry, register indexes.
// ----------------------------------------------------------------------------
package lbp_pkg;

   localparam int MAX_COLUMN_LENGTH = 1024;
   localparam int PIXEL_BITS        = 8;

   localparam int ROW_BITS  = $clog2(MAX_COLUMN_LENGTH);
   localparam int LEN_BITS  = ROW_BITS + 1;
   localparam int COL_BITS  = 16;
   localparam int ENTRY_BITS = 2 * PIXEL_BITS;

   localparam int CSR_LEN_BITS   = 11;
   localparam int CSR_COUNT_BITS = 16;
   localparam int CSR_DATA_BITS  = 16;

   typedef enum logic [0:0] {
      CSR_COLUMN_LENGTH = 1'b0,
      CSR_COLUMN_COUNT  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] pixel;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [9:0]  row;
      logic [15:0] col;
      logic [7:0]  pattern;
      logic        final_result;
   } rsp_type;

endpackage

// File: hdl/lbp_ram.sv
// ----------------------------------------------------------------------------
// lbp_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module lbp_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hdl/lbp_3x3_filter.sv
// ----------------------------------------------------------------------------
// lbp_3x3_filter: 3x3 local binary pattern over a column-major pixel stream
// Keeps the two previous columns in one RAM and emits one pattern per
// interior pixel.
// ----------------------------------------------------------------------------
// The filter takes one pixel request per clock when not stalled, top to bottom
// within a column and column after column, and returns one response for each
// interior pixel, via the stage 1 and output registers, after the request
// that completes its 3x3 window. Border pixels produce no response. The
// sustained rate of one pixel per clock is set by the column store, a RAM with
// one read and one write port: each pixel reads its row entry in the request
// cycle and writes it back as it leaves stage 1, with forwarding when a frame
// restart revisits the row just written. The store needs no clearing after
// reset. Write column_length and column_count only while the filter is idle.
module lbp_3x3_filter (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  lbp_pkg::req_type            req_data,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output lbp_pkg::rsp_type            rsp_data,
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  lbp_pkg::csr_index_type      csr_index,
   input  logic [lbp_pkg::CSR_DATA_BITS-1:0] csr_data
);
   import lbp_pkg::*;

   typedef logic [PIXEL_BITS-1:0] pix_type;

   // configuration
   logic [CSR_LEN_BITS-1:0]   column_length_ff;
   logic [CSR_COUNT_BITS-1:0] column_count_ff;
   logic [LEN_BITS-1:0]       len_eff;
   logic [COL_BITS-1:0]       cnt_eff;

   // position
   logic [ROW_BITS-1:0] row_ff, row_in;
   logic [COL_BITS-1:0] col_ff, col_in;
   logic [ROW_BITS-1:0] row_start;
   logic [COL_BITS-1:0] col_start;
   logic [COL_BITS:0]   col_adv;
   logic [ROW_BITS-1:0] cur_row;
   logic [COL_BITS-1:0] cur_col;
   logic [LEN_BITS-1:0] row_next;
   logic [COL_BITS:0]   col_next;

   // stage 1
   logic                  s1_valid_ff;
   logic [ROW_BITS-1:0]   s1_addr_ff;
   pix_type               s1_pixel_ff;
   logic [9:0]            s1_row_ff;
   logic [COL_BITS-1:0]   s1_col_ff;
   logic                  s1_interior_ff;
   logic                  s1_final_ff;
   logic                  fwd_ff;
   logic [ENTRY_BITS-1:0] fwd_data_ff;
   pix_type               win_ff [6];

   logic [ENTRY_BITS-1:0] ram_rd_data;
   logic [ENTRY_BITS-1:0] entry;
   logic [ENTRY_BITS-1:0] wr_entry;
   pix_type               older_pix;
   pix_type               newer_pix;
   pix_type               ctr;
   logic [7:0]            pattern;

   // output register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   logic req_acc;
   logic out_free;
   logic s1_fire;
   logic fwd_hit;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_length_ff <= CSR_LEN_BITS'(1024);
         column_count_ff  <= CSR_COUNT_BITS'(1024);
      end else if (csr_valid) begin
         case (csr_index)
            CSR_COLUMN_LENGTH: column_length_ff <= csr_data[CSR_LEN_BITS-1:0];
            CSR_COLUMN_COUNT:  column_count_ff  <= csr_data[CSR_COUNT_BITS-1:0];
            default: ;
         endcase
      end
   end

   // saturate the registers to the supported geometry
   always_comb begin
      if (column_length_ff < CSR_LEN_BITS'(3)) begin
         len_eff = LEN_BITS'(3);
      end else if (32'(column_length_ff) > MAX_COLUMN_LENGTH) begin
         len_eff = LEN_BITS'(MAX_COLUMN_LENGTH);
      end else begin
         len_eff = LEN_BITS'(column_length_ff);
      end
      if (column_count_ff < CSR_COUNT_BITS'(3)) begin
         cnt_eff = COL_BITS'(3);
      end else begin
         cnt_eff = COL_BITS'(column_count_ff);
      end
   end

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_fire   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign req_acc   = req_valid && !req_stall;

   // position of the incoming pixel and of the one after it
   always_comb begin
      row_start = req_data.frame_start ? '0 : row_ff;
      col_start = req_data.frame_start ? '0 : col_ff;
      if ({1'b0, row_start} >= len_eff) begin
         cur_row = '0;
         col_adv = {1'b0, col_start} + (COL_BITS+1)'(1);
      end else begin
         cur_row = row_start;
         col_adv = {1'b0, col_start};
      end
      cur_col = (col_adv >= {1'b0, cnt_eff}) ? '0 : col_adv[COL_BITS-1:0];

      row_next = {1'b0, cur_row} + LEN_BITS'(1);
      col_next = {1'b0, cur_col} + (COL_BITS+1)'(1);
      if (row_next >= len_eff) begin
         row_in = '0;
         col_in = (col_next >= {1'b0, cnt_eff}) ? '0 : col_next[COL_BITS-1:0];
      end else begin
         row_in = row_next[ROW_BITS-1:0];
         col_in = cur_col;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else if (req_acc) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // the entry being written back this cycle is the one the new request reads
   assign fwd_hit = s1_fire && (s1_addr_ff == cur_row);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_acc) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_addr_ff     <= cur_row;
         s1_pixel_ff    <= req_data.pixel[PIXEL_BITS-1:0];
         s1_row_ff      <= 10'(cur_row - ROW_BITS'(1));
         s1_col_ff      <= cur_col - COL_BITS'(1);
         s1_interior_ff <= (cur_row >= ROW_BITS'(2)) && (cur_col >= COL_BITS'(2));
         s1_final_ff    <= ({1'b0, cur_row} == len_eff - LEN_BITS'(1))
                           && (cur_col == cnt_eff - COL_BITS'(1));
         fwd_ff         <= fwd_hit;
         fwd_data_ff    <= wr_entry;
      end
   end

   lbp_ram #(
      .WIDTH (ENTRY_BITS),
      .DEPTH (MAX_COLUMN_LENGTH)
   ) u_column_ram (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_entry),
      .rd_en   (req_acc),
      .rd_addr (cur_row),
      .rd_data (ram_rd_data)
   );

   // entry layout: older column in the upper half, newer column in the lower
   always_comb begin
      entry     = fwd_ff ? fwd_data_ff : ram_rd_data;
      older_pix = entry[ENTRY_BITS-1:PIXEL_BITS];
      newer_pix = entry[PIXEL_BITS-1:0];
      wr_entry  = {newer_pix, s1_pixel_ff};
      ctr       = win_ff[3];
      pattern[0] = win_ff[0] < ctr;
      pattern[1] = win_ff[2] < ctr;
      pattern[2] = win_ff[4] < ctr;
      pattern[3] = win_ff[1] < ctr;
      pattern[4] = win_ff[5] < ctr;
      pattern[5] = older_pix < ctr;
      pattern[6] = newer_pix < ctr;
      pattern[7] = s1_pixel_ff < ctr;
   end

   // advance the window one row
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 6; i++) begin
            win_ff[i] <= '0;
         end
      end else if (s1_fire) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= older_pix;
         win_ff[2] <= win_ff[3];
         win_ff[3] <= newer_pix;
         win_ff[4] <= win_ff[5];
         win_ff[5] <= s1_pixel_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_fire) begin
         rsp_valid_ff <= s1_interior_ff;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff.row          <= s1_row_ff;
         rsp_data_ff.col          <= s1_col_ff;
         rsp_data_ff.pattern      <= pattern;
         rsp_data_ff.final_result <= s1_final_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the 3x3 local binary pattern filter
// Streams column-major pixel requests with random gaps and response stalls,
// predicts each interior pattern and compares every response in order.
// ----------------------------------------------------------------------------
module testbench;
   import lbp_pkg::*;

   localparam int DRAIN_CYCLES = 8;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_ITEMS = 1650;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic    csr_valid = 1'b0;
   logic    csr_ready;
   csr_index_type csr_index = CSR_COLUMN_LENGTH;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   lbp_3x3_filter dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   req_type pixel_queue[$];
   rsp_type pattern_queue[$];

   // filter mirror
   logic [CSR_LEN_BITS-1:0]   cfg_length = 11'd1024;
   logic [CSR_COUNT_BITS-1:0] cfg_count  = 16'd1024;
   logic [PIXEL_BITS-1:0] older_col [MAX_COLUMN_LENGTH];
   logic [PIXEL_BITS-1:0] newer_col [MAX_COLUMN_LENGTH];
   int                    row_writes [MAX_COLUMN_LENGTH];
   logic [PIXEL_BITS-1:0] win [6];
   int row_pos = 0;
   int col_pos = 0;

   int error_count  = 0;
   int cycle_count  = 0;
   int gap_left     = 0;
   int stall_left   = 0;
   int req_idle_pct = 0;
   int rsp_busy_pct = 0;

   initial begin
      for (int i = 0; i < MAX_COLUMN_LENGTH; i++) begin
         older_col[i]  = '0;
         newer_col[i]  = '0;
         row_writes[i] = 0;
      end
      for (int i = 0; i < 6; i++) win[i] = '0;
   end

   function automatic int column_rows();
      if (cfg_length < 3) return 3;
      if (cfg_length > MAX_COLUMN_LENGTH) return MAX_COLUMN_LENGTH;
      return int'(cfg_length);
   endfunction

   function automatic int image_columns();
      if (cfg_count < 3) return 3;
      return int'(cfg_count);
   endfunction

   // both halves of an entry hold pixel data after two writes
   function automatic bit rows_filled(int n);
      for (int i = 0; i < n; i++) begin
         if (row_writes[i] < 2) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void compute_lbp(req_type item);
      int rows, cols, r, c;
      logic [PIXEL_BITS-1:0] a, b, p, ctr;
      rsp_type res;
      rows = column_rows();
      cols = image_columns();
      p = item.pixel;
      if (item.frame_start) begin
         row_pos = 0;
         col_pos = 0;
      end
      // wrap a position left out of range by a register change
      if (row_pos >= rows) begin
         row_pos = 0;
         col_pos++;
      end
      if (col_pos >= cols) col_pos = 0;
      r = row_pos;
      c = col_pos;
      a = older_col[r];
      b = newer_col[r];
      if (r >= 2 && c >= 2) begin
         ctr = win[3];
         res.row          = 10'(r - 1);
         res.col          = 16'(c - 1);
         res.pattern      = {p < ctr, b < ctr, a < ctr, win[5] < ctr,
                             win[1] < ctr, win[4] < ctr, win[2] < ctr, win[0] < ctr};
         res.final_result = (r == rows - 1) && (c == cols - 1);
         pattern_queue.push_back(res);
      end
      win[0] = win[1];
      win[1] = a;
      win[2] = win[3];
      win[3] = b;
      win[4] = win[5];
      win[5] = p;
      older_col[r] = b;
      newer_col[r] = p;
      row_writes[r]++;
      row_pos = r + 1;
      if (row_pos >= rows) begin
         row_pos = 0;
         col_pos = c + 1;
         if (col_pos >= cols) col_pos = 0;
      end
   endfunction

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 70) return $urandom_range(1, 2);
      if (pick < 95) return $urandom_range(3, 8);
      return $urandom_range(20, 40);
   endfunction

   function automatic logic [7:0] gen_pixel(int style, logic [7:0] base);
      logic [7:0] extremes [5];
      extremes = '{8'd0, 8'd1, 8'd128, 8'd254, 8'd255};
      case (style)
         0: return 8'($urandom_range(0, 255));
         1: return base + 8'($urandom_range(0, 3)) - 8'd1;
         default: return extremes[$urandom_range(0, 4)];
      endcase
   endfunction

   task automatic report(string msg);
      error_count++;
      if (error_count <= 10) $display("%s", msg);
   endtask

   task automatic push_pixel(logic [7:0] px, bit fs);
      req_type item;
      item.pixel       = px;
      item.frame_start = fs;
      pixel_queue.push_back(item);
   endtask

   task automatic wait_idle();
      int quiet;
      quiet = 0;
      // hold until the bench has been quiet long enough for requests that
      // make no response to leave the pipeline
      while (quiet < DRAIN_CYCLES) begin
         @(posedge clock);
         if (pixel_queue.size() != 0 || req_valid || pattern_queue.size() != 0)
            quiet = 0;
         else
            quiet++;
      end
   endtask

   task automatic write_csr(csr_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_COLUMN_LENGTH) cfg_length = value[CSR_LEN_BITS-1:0];
      else cfg_count = value;
   endtask

   task automatic run_phase(logic [15:0] len_val, logic [15:0] cnt_val, int n_items,
                            bit restart);
      int style;
      logic [7:0] base;
      bit fs;
      wait_idle();
      write_csr(CSR_COLUMN_LENGTH, len_val);
      write_csr(CSR_COLUMN_COUNT, cnt_val);
      // continue the image only where every row to be read holds written data
      if (!restart && !rows_filled(column_rows())) restart = 1'b1;
      req_idle_pct = ($urandom_range(0, 3) == 0) ? 0 : 10 * $urandom_range(1, 5);
      rsp_busy_pct = ($urandom_range(0, 3) == 0) ? 0 : 10 * $urandom_range(1, 5);
      style = $urandom_range(0, 2);
      base  = 8'($urandom_range(0, 255));
      for (int i = 0; i < n_items; i++) begin
         fs = (i == 0 && restart) || ($urandom_range(0, 399) == 0);
         push_pixel(gen_pixel(style, base), fs);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) compute_lbp(req_data);
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pixel_queue.size() > 0) begin
               req_data  <= pixel_queue.pop_front();
               req_valid <= 1'b1;
               if ($urandom_range(0, 99) < req_idle_pct) gap_left = gap_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pattern_queue.size() == 0) begin
               report($sformatf("unexpected response row=%0d col=%0d pattern=%02h final=%0b",
                                rsp_data.row, rsp_data.col, rsp_data.pattern,
                                rsp_data.final_result));
            end else begin
               want = pattern_queue.pop_front();
               if (rsp_data !== want)
                  report($sformatf({"mismatch: expected row=%0d col=%0d pattern=%02h ",
                                    "final=%0b, got row=%0d col=%0d pattern=%02h final=%0b"},
                                   want.row, want.col, want.pattern, want.final_result,
                                   rsp_data.row, rsp_data.col, rsp_data.pattern,
                                   rsp_data.final_result));
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if ($urandom_range(0, 99) < rsp_busy_pct) stall_left = gap_length();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int random_items;
      int kind, rows, cols, n;
      logic [15:0] len_pick [4];
      random_items = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // bits above the length register drop
      write_csr(CSR_COLUMN_LENGTH, 16'hF803);
      write_csr(CSR_COLUMN_COUNT, 16'd3);
      // mixed neighbors around a center of 128, equal neighbor left clear
      push_pixel(8'd0, 1'b1);
      push_pixel(8'd128, 1'b0);
      push_pixel(8'd1, 1'b0);
      push_pixel(8'd255, 1'b0);
      push_pixel(8'd128, 1'b0);
      push_pixel(8'd254, 1'b0);
      push_pixel(8'd127, 1'b0);
      push_pixel(8'd129, 1'b0);
      push_pixel(8'd0, 1'b0);
      // next image starts on wrap, all equal
      repeat (9) push_pixel(8'd255, 1'b0);
      // stray pixels, then a restart with every neighbor below the center
      push_pixel(8'd17, 1'b0);
      push_pixel(8'd200, 1'b0);
      push_pixel(8'd0, 1'b1);
      repeat (3) push_pixel(8'd0, 1'b0);
      push_pixel(8'd255, 1'b0);
      repeat (4) push_pixel(8'd0, 1'b0);

      while (random_items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         case (kind)
            0: begin
               n = 9 * $urandom_range(2, 6) + $urandom_range(0, 8);
               run_phase(16'($urandom_range(0, 2)), 16'($urandom_range(0, 2)), n, 1'b1);
            end
            1: begin
               n = $urandom_range(100, 250);
               run_phase(16'($urandom_range(3, 6)), 16'hFFFF, n, 1'b1);
            end
            2, 3: begin
               len_pick = '{16'd0, 16'd1100, 16'd2047, 16'($urandom_range(3, 30))};
               n = $urandom_range(10, 60);
               run_phase(len_pick[$urandom_range(0, 3)], 16'($urandom_range(0, 8)), n, 1'b0);
            end
            default: begin
               rows = $urandom_range(3, 24);
               cols = $urandom_range(3, 10);
               n = rows * cols * $urandom_range(1, 3) + $urandom_range(0, 2 * rows);
               run_phase(16'(rows), 16'(cols), n, $urandom_range(0, 3) != 0);
            end
         endcase
         random_items += n;
      end

      wait_idle();
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
